// File: sv/channel_load_ewma_estimator_assert.svh
// assertion macros for the channel load estimator
`ifndef CHANNEL_LOAD_EWMA_ESTIMATOR_ASSERT_SVH
`define CHANNEL_LOAD_EWMA_ESTIMATOR_ASSERT_SVH

// same-cycle implication, disabled while in reset
`define CLE_ASSERT_NOW(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error(msg);

// next-cycle implication, disabled while in reset
`define CLE_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`endif

// File: sv/cle_pkg.sv
// shared types, constants and helpers of the channel load estimator
`default_nettype none

package cle_pkg;

  // field widths
  localparam int unsigned FREQ_W  = 13;
  localparam int unsigned NOISE_W = 8;
  localparam int unsigned CNT_W   = 64;
  localparam int unsigned LOAD_W  = 25;
  localparam int unsigned EWMA_W  = 15;
  localparam int unsigned PCT_W   = 7;

  // serial divider widths
  localparam int unsigned DIV_W   = 39;
  localparam int unsigned QUO_W   = 25;
  localparam int unsigned STEP_W  = 5;

  // apb register map
  localparam int unsigned PADDR_W = 4;
  localparam logic [1:0] REG_NODE_FREQ = 2'd0;
  localparam logic [1:0] REG_PHY_MODE  = 2'd1;
  localparam logic [1:0] REG_CHAN_W    = 2'd2;

  // divide lengths: percentage has 7 quotient bits, load has 25
  localparam logic [STEP_W-1:0] PCT_STEPS  = 5'd7;
  localparam logic [STEP_W-1:0] LOAD_STEPS = 5'd25;

  localparam logic [PCT_W-1:0]  PCT_FULL   = 7'd100;
  localparam logic [7:0]        W_OLD      = 8'd218;
  localparam logic [7:0]        W_NEW      = 8'd38;
  localparam logic [12:0]       BAND_SPLIT = 13'd4000;
  localparam logic [30:0]       FULL_TOTAL = 31'(28600) << 16;

  // channel width codes
  localparam logic [1:0] CW_20 = 2'd0;
  localparam logic [1:0] CW_40 = 2'd1;

  // phy mode codes
  localparam logic [1:0] PHY_LEGACY = 2'd0;
  localparam logic [1:0] PHY_HT     = 2'd1;
  localparam logic [1:0] PHY_VHT    = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PREP,
    S_DIV1,
    S_EWMA,
    S_TOTAL,
    S_DIV2,
    S_WAIT
  } cle_state_e;

  typedef struct packed {
    logic              start;
    logic [STEP_W-1:0] steps;
  } cle_div_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } cle_div_sts_t;

  // airtime divisor per phy mode
  function automatic logic [8:0] phy_div(input logic [1:0] mode);
    logic [8:0] d;
    case (mode)
      PHY_LEGACY: d = 9'd108;
      PHY_HT:     d = 9'd150;
      PHY_VHT:    d = 9'd200;
      default:    d = 9'd286;
    endcase
    return d;
  endfunction

endpackage

`default_nettype wire

// File: sv/cle_if.sv
// valid/ready channel interfaces for survey samples and load words
`default_nettype none

interface cle_in_if;
  logic                               valid;
  logic                               ready;
  logic [cle_pkg::FREQ_W-1:0]         survey_freq;
  logic signed [cle_pkg::NOISE_W-1:0] noise_dbm;
  logic [cle_pkg::CNT_W-1:0]          channel_time;
  logic [cle_pkg::CNT_W-1:0]          busy_time;

  modport source (output valid, survey_freq, noise_dbm, channel_time, busy_time,
                  input ready);
  modport sink   (input valid, survey_freq, noise_dbm, channel_time, busy_time,
                  output ready);
endinterface

interface cle_out_if;
  logic                               valid;
  logic                               ready;
  logic [cle_pkg::LOAD_W-1:0]         load_value;
  logic signed [cle_pkg::NOISE_W-1:0] noise_out;

  modport source (output valid, load_value, noise_out, input ready);
  modport sink   (input valid, load_value, noise_out, output ready);
endinterface

`default_nettype wire

// File: sv/cle_div.sv
// restoring serial divider, one quotient bit per cycle
`default_nettype none

module cle_div (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire cle_pkg::cle_div_ctl_t        ctl_i,
  input  wire logic [cle_pkg::DIV_W-1:0]    num_i,
  input  wire logic [cle_pkg::DIV_W-1:0]    den_i,
  output cle_pkg::cle_div_sts_t             sts_o,
  output logic [cle_pkg::QUO_W-1:0]         quo_o
);

  logic [cle_pkg::DIV_W-1:0]  rem_q, rem_d;
  logic [cle_pkg::DIV_W-1:0]  den_q, den_d;
  logic [cle_pkg::QUO_W-1:0]  quo_q, quo_d;
  logic [cle_pkg::STEP_W-1:0] cnt_q, cnt_d;
  logic                       busy_q, busy_d;
  logic                       done_q, done_d;
  logic [cle_pkg::DIV_W:0]    diff;
  logic                       fits;

  // the one subtractor, shared by both divides
  assign diff = {1'b0, rem_q} - {1'b0, den_q};
  assign fits = ~diff[cle_pkg::DIV_W];

  always_comb begin
    rem_d  = rem_q;
    den_d  = den_q;
    quo_d  = quo_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (ctl_i.start) begin
      rem_d  = num_i;
      den_d  = den_i;
      quo_d  = '0;
      cnt_d  = ctl_i.steps;
      busy_d = 1'b1;
    end else if (busy_q) begin
      rem_d = fits ? diff[cle_pkg::DIV_W-1:0] : rem_q;
      den_d = den_q >> 1;
      quo_d = {quo_q[cle_pkg::QUO_W-2:0], fits};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == cle_pkg::STEP_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    den_q <= den_d;
    quo_q <= quo_d;
  end

  assign sts_o.busy = busy_q;
  assign sts_o.done = done_q;
  assign quo_o      = quo_q;

endmodule

`default_nettype wire

// File: sv/channel_load_ewma_estimator.sv
// channel load estimator top level: apb registers, sequencer and ewma
`default_nettype none

// Takes one survey word at a time and returns one load word for each sample
// whose frequency matches node_freq; other samples are dropped without any
// state change. A matching sample goes from acceptance through the prep
// state, the percentage divide, the ewma update, the total, the load
// divide and the wait for the output register. The percentage divide is
// skipped when busy time reaches channel time and the percentage saturates;
// it and the ewma update are skipped when no busy percentage is formed (first
// sample, zero time delta). The single serial divider makes one quotient bit
// per cycle: 7 bits for the busy percentage and 25 bits for the load.
// Input ready is high only while the sequencer is idle; a finished load
// word waits in the output register and does not hold up the next sample,
// although the next load word waits for that register to empty. Registers
// (node_freq at 0x0, phy_mode at 0x4, channel_width at 0x8) are written
// through the apb port and should be changed only while idle.
module channel_load_ewma_estimator (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [cle_pkg::PADDR_W-1:0]   paddr,
  input  wire logic [31:0]                   pwdata,
  output logic      [31:0]                   prdata,
  output logic                               pready,
  cle_in_if.sink                             in_i,
  cle_out_if.source                          out_o
);

  // configuration registers
  logic [cle_pkg::FREQ_W-1:0] node_freq_q;
  logic [1:0]                 phy_mode_q;
  logic [1:0]                 chan_w_q;
  logic                       cfg_wr;

  // sequencer
  cle_pkg::cle_state_e state_q, state_d;

  // estimator state
  logic [cle_pkg::CNT_W-1:0]          prev_time_q;
  logic [cle_pkg::CNT_W-1:0]          prev_busy_q;
  logic [cle_pkg::EWMA_W-1:0]         ewma_q;
  logic                               seeded_q;
  logic signed [cle_pkg::NOISE_W-1:0] noise_q;

  // per-sample working registers
  logic [31:0]                dt_q;
  logic [31:0]                db_q;
  logic [cle_pkg::PCT_W-1:0]  pct_q;

  // output word register
  logic                               out_valid_q;
  logic [cle_pkg::LOAD_W-1:0]         load_q;
  logic signed [cle_pkg::NOISE_W-1:0] noise_out_q;

  // divider hookup
  cle_pkg::cle_div_ctl_t      div_ctl;
  cle_pkg::cle_div_sts_t      div_sts;
  logic [cle_pkg::DIV_W-1:0]  div_num;
  logic [cle_pkg::DIV_W-1:0]  div_den;
  logic [cle_pkg::QUO_W-1:0]  div_quo;

  logic        in_acc;
  logic        freq_hit;
  logic        out_free;
  logic        in_div;
  logic        dt_zero;
  logic        busy_full;
  logic [38:0] busy_x100;
  logic [30:0] total;
  logic [1:0]  shift;
  logic [11:0] den_load;
  logic [23:0] ewma_mix;
  logic [cle_pkg::EWMA_W-1:0] pct_q8;

  // ---------------------------------------------------------------------
  // apb register port, zero wait states
  // ---------------------------------------------------------------------
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      node_freq_q <= '0;
      phy_mode_q  <= '0;
      chan_w_q    <= '0;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        cle_pkg::REG_NODE_FREQ: node_freq_q <= pwdata[cle_pkg::FREQ_W-1:0];
        cle_pkg::REG_PHY_MODE:  phy_mode_q  <= pwdata[1:0];
        cle_pkg::REG_CHAN_W:    chan_w_q    <= pwdata[1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      cle_pkg::REG_NODE_FREQ: prdata = 32'(node_freq_q);
      cle_pkg::REG_PHY_MODE:  prdata = 32'(phy_mode_q);
      cle_pkg::REG_CHAN_W:    prdata = 32'(chan_w_q);
      default:                prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------
  // handshakes
  // ---------------------------------------------------------------------
  assign in_i.ready = (state_q == cle_pkg::S_IDLE);
  assign in_acc     = in_i.valid && in_i.ready;
  assign freq_hit   = (in_i.survey_freq == node_freq_q);
  // output register can take a new word when empty or being drained
  assign out_free   = !out_valid_q || out_o.ready;

  assign out_o.valid      = out_valid_q;
  assign out_o.load_value = load_q;
  assign out_o.noise_out  = noise_out_q;

  // sequencer is in one of the two divide states
  assign in_div = (state_q == cle_pkg::S_DIV1) || (state_q == cle_pkg::S_DIV2);

  // ---------------------------------------------------------------------
  // datapath helpers
  // ---------------------------------------------------------------------
  assign dt_zero   = (dt_q == '0);
  // busy at or above channel time saturates the percentage at 100
  assign busy_full = (db_q >= dt_q);
  // 100 * busy delta as shifts and adds
  assign busy_x100 = {1'b0, db_q, 6'b0} + {2'b0, db_q, 5'b0} + {5'b0, db_q, 2'b0};

  // ewma in unsigned q7.8, weights 218/256 and 38/256, round half up
  assign pct_q8   = {pct_q, 8'b0};
  assign ewma_mix = (24'(cle_pkg::W_OLD) * 24'(ewma_q)
                   + 24'(cle_pkg::W_NEW) * 24'(pct_q8)
                   + 24'd128) >> 8;

  // total in q.16: full airtime while the average reads zero
  assign total = (ewma_q == '0) ? cle_pkg::FULL_TOTAL : {8'b0, ewma_q, 8'b0};

  always_comb begin
    shift = (node_freq_q > cle_pkg::BAND_SPLIT) ? 2'd1 : 2'd0;
    if (chan_w_q == cle_pkg::CW_40) begin
      shift = shift + 2'd1;
    end else if (chan_w_q != cle_pkg::CW_20) begin
      shift = shift + 2'd2;
    end
  end

  assign den_load = 12'(cle_pkg::phy_div(phy_mode_q)) << shift;

  // ---------------------------------------------------------------------
  // sequencer: next state
  // ---------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    case (state_q)
      cle_pkg::S_IDLE: begin
        if (in_acc && freq_hit) begin
          state_d = cle_pkg::S_PREP;
        end
      end
      cle_pkg::S_PREP: begin
        if (dt_zero) begin
          state_d = cle_pkg::S_TOTAL;
        end else if (busy_full) begin
          state_d = cle_pkg::S_EWMA;
        end else begin
          state_d = cle_pkg::S_DIV1;
        end
      end
      cle_pkg::S_DIV1: begin
        if (div_sts.done) begin
          state_d = cle_pkg::S_EWMA;
        end
      end
      cle_pkg::S_EWMA:  state_d = cle_pkg::S_TOTAL;
      cle_pkg::S_TOTAL: state_d = cle_pkg::S_DIV2;
      cle_pkg::S_DIV2: begin
        if (div_sts.done) begin
          state_d = cle_pkg::S_WAIT;
        end
      end
      cle_pkg::S_WAIT: begin
        if (out_free) begin
          state_d = cle_pkg::S_IDLE;
        end
      end
      default: state_d = cle_pkg::S_IDLE;
    endcase
  end

  // ---------------------------------------------------------------------
  // sequencer: divider commands
  // ---------------------------------------------------------------------
  always_comb begin
    div_ctl.start = 1'b0;
    div_ctl.steps = cle_pkg::LOAD_STEPS;
    div_num       = '0;
    div_den       = '0;
    case (state_q)
      cle_pkg::S_PREP: begin
        // percentage below 100, so seven quotient bits suffice
        div_ctl.start = !dt_zero && !busy_full;
        div_ctl.steps = cle_pkg::PCT_STEPS;
        div_num       = busy_x100;
        div_den       = {1'b0, dt_q, 6'b0};
      end
      cle_pkg::S_TOTAL: begin
        div_ctl.start = 1'b1;
        div_ctl.steps = cle_pkg::LOAD_STEPS;
        div_num       = {8'b0, total};
        div_den       = {3'b0, den_load, 24'b0};
      end
      default: ;
    endcase
  end

  cle_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (div_ctl),
    .num_i  (div_num),
    .den_i  (div_den),
    .sts_o  (div_sts),
    .quo_o  (div_quo)
  );

  // ---------------------------------------------------------------------
  // state and estimator registers
  // ---------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= cle_pkg::S_IDLE;
      prev_time_q <= '0;
      prev_busy_q <= '0;
      ewma_q      <= '0;
      seeded_q    <= 1'b0;
      noise_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;

      if (in_acc && freq_hit) begin
        if (in_i.noise_dbm != '0) begin
          noise_q <= in_i.noise_dbm;
        end
        prev_time_q <= in_i.channel_time;
        prev_busy_q <= in_i.busy_time;
      end

      if (state_q == cle_pkg::S_EWMA) begin
        seeded_q <= 1'b1;
        ewma_q   <= seeded_q ? ewma_mix[cle_pkg::EWMA_W-1:0] : pct_q8;
      end

      if (state_q == cle_pkg::S_WAIT && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // working and output word registers
  always_ff @(posedge clk_i) begin
    if (in_acc && freq_hit) begin
      // deltas wrap at 32 bits, so only the low halves matter
      if (prev_time_q != '0) begin
        dt_q <= in_i.channel_time[31:0] - prev_time_q[31:0];
        db_q <= in_i.busy_time[31:0] - prev_busy_q[31:0];
      end else begin
        dt_q <= '0;
        db_q <= '0;
      end
    end
    if (state_q == cle_pkg::S_PREP && busy_full) begin
      pct_q <= cle_pkg::PCT_FULL;
    end else if (state_q == cle_pkg::S_DIV1 && div_sts.done) begin
      pct_q <= div_quo[cle_pkg::PCT_W-1:0];
    end
    if (state_q == cle_pkg::S_WAIT && out_free) begin
      load_q      <= div_quo;
      noise_out_q <= noise_q;
    end
  end

  // ---------------------------------------------------------------------
  // checks
  // ---------------------------------------------------------------------
`include "channel_load_ewma_estimator_assert.svh"

  `CLE_ASSERT_NOW(a_div_busy_blocks_input, div_sts.busy, !in_i.ready, "sample taken mid divide")
  `CLE_ASSERT_NOW(a_done_in_div_state, div_sts.done, in_div, "stray divider done")
  `CLE_ASSERT_NOW(a_ewma_in_range, 1'b1, ewma_q <= 15'd25600, "ewma above 100 percent")
  `CLE_ASSERT_NOW(a_unseeded_is_zero, !seeded_q, ewma_q == '0, "ewma nonzero before seeding")

endmodule

`default_nettype wire
